// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the valve control rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property, muted while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked on every edge
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/tdv_pkg.sv =====
// ----------------------------------------------------------------------------
// tdv_pkg
// shared types and constants of the touch dispense valve control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdv_pkg;

    localparam int unsigned NUM_PADS    = 4;
    localparam int unsigned RD_W        = 16;
    localparam int unsigned PRESET_W    = 20;
    localparam int unsigned PACKED_W    = 60;
    localparam logic [31:0] MAX_ON_MS   = 32'd600000;
    localparam logic [15:0] THR_RESET   = 16'd58982;
    localparam logic [15:0] PERIOD_RESET = 16'd10;

    // configuration register indexes
    localparam logic [2:0] CFG_THR0        = 3'd0;
    localparam logic [2:0] CFG_THR1        = 3'd1;
    localparam logic [2:0] CFG_THR2        = 3'd2;
    localparam logic [2:0] CFG_THR3        = 3'd3;
    localparam logic [2:0] CFG_PRESET_TIME = 3'd4;
    localparam logic [2:0] CFG_PRESET_VOL  = 3'd5;
    localparam logic [2:0] CFG_LIMIT_TIME  = 3'd6;
    localparam logic [2:0] CFG_PERIOD      = 3'd7;

    typedef enum logic [1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_LIMIT    = 2'd1,
        CAUSE_SAFETY   = 2'd2,
        CAUSE_STOP_PAD = 2'd3
    } t_cause;

    typedef struct packed {
        logic [NUM_PADS-1:0][RD_W-1:0] thr;
        logic [PACKED_W-1:0]           preset_times;
        logic [PACKED_W-1:0]           preset_volumes;
        logic                          limit_by_time;
        logic [15:0]                   period;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/touch_dispense_valve_control.sv =====
// ----------------------------------------------------------------------------
// touch_dispense_valve_control
// touch pad driven dispense valve with preset time or volume and safety cutoff
// ----------------------------------------------------------------------------
// path: an accepted input beat is held in the input register, its result beat in the result register on m_axis
// throughput: one tick per cycle; input register feeds one pass of compare and
//   valve logic into the result register; a held result beat stalls the input
//   once the input register is full
// reset: synchronous active low; clears pad history, flags, valve state and
//   loads register defaults (threshold 58982, period 10, limit by time)
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module touch_dispense_valve_control (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_addr,
    input  wire logic [59:0]  i_cfg_data,
    // tick stream in
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pad0_reading[15:0], pad1_reading[31:16], pad2_reading[47:32],
    // pad3_reading[63:48], pulse_count[95:64], now_ms[127:96]
    input  wire logic [127:0] s_axis_tdata,
    // result stream out
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // valve_drive[0], touched_mask[4:1], stop_cause[6:5], zero[7]
    output logic [7:0]        m_axis_tdata
);
    import tdv_pkg::*;

    t_cfg r_cfg;

    // input register
    logic                          r_in_valid;
    logic [NUM_PADS-1:0][RD_W-1:0] r_rd;
    logic [31:0]                   r_pulses;
    logic [31:0]                   r_now;

    // valve state
    logic                r_valve_on;
    logic [31:0]         r_start_time;
    logic [31:0]         r_start_pulses;
    logic [PRESET_W-1:0] r_time_limit;
    logic [PRESET_W-1:0] r_vol_limit;

    // result register
    logic                r_out_valid;
    logic                r_out_drive;
    logic [NUM_PADS-1:0] r_out_flags;
    t_cause              r_out_cause;

    logic                advance;
    logic [NUM_PADS-1:0] flags;

    logic                n_valve_on;
    logic [31:0]         n_start_time;
    logic [31:0]         n_start_pulses;
    logic [PRESET_W-1:0] n_time_limit;
    logic [PRESET_W-1:0] n_vol_limit;
    logic                n_drive;
    t_cause              n_cause;
    logic [31:0]         elapsed;
    logic [31:0]         dispensed;
    logic                over;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr            <= {NUM_PADS{THR_RESET}};
            r_cfg.preset_times   <= '0;
            r_cfg.preset_volumes <= '0;
            r_cfg.limit_by_time  <= 1'b1;
            r_cfg.period         <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_THR0:        r_cfg.thr[0] <= i_cfg_data[15:0];
                CFG_THR1:        r_cfg.thr[1] <= i_cfg_data[15:0];
                CFG_THR2:        r_cfg.thr[2] <= i_cfg_data[15:0];
                CFG_THR3:        r_cfg.thr[3] <= i_cfg_data[15:0];
                CFG_PRESET_TIME: r_cfg.preset_times <= i_cfg_data;
                CFG_PRESET_VOL:  r_cfg.preset_volumes <= i_cfg_data;
                CFG_LIMIT_TIME:  r_cfg.limit_by_time <= i_cfg_data[0];
                CFG_PERIOD:      r_cfg.period <= i_cfg_data[15:0];
            endcase
        end
    end

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_rd     <= s_axis_tdata[63:0];
            r_pulses <= s_axis_tdata[95:64];
            r_now    <= s_axis_tdata[127:96];
        end
    end

    tdv_touch_eval u_touch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_step     (advance),
        .i_readings (r_rd),
        .o_flags    (flags)
    );

    always_comb begin
        n_valve_on     = r_valve_on;
        n_start_time   = r_start_time;
        n_start_pulses = r_start_pulses;
        n_time_limit   = r_time_limit;
        n_vol_limit    = r_vol_limit;
        n_cause        = CAUSE_NONE;

        // first touched preset pad wins
        if (!r_valve_on) begin
            priority if (flags[1]) begin
                n_time_limit = r_cfg.preset_times[0 +: PRESET_W];
                n_vol_limit  = r_cfg.preset_volumes[0 +: PRESET_W];
                n_valve_on   = 1'b1;
            end else if (flags[2]) begin
                n_time_limit = r_cfg.preset_times[PRESET_W +: PRESET_W];
                n_vol_limit  = r_cfg.preset_volumes[PRESET_W +: PRESET_W];
                n_valve_on   = 1'b1;
            end else if (flags[3]) begin
                n_time_limit = r_cfg.preset_times[2*PRESET_W +: PRESET_W];
                n_vol_limit  = r_cfg.preset_volumes[2*PRESET_W +: PRESET_W];
                n_valve_on   = 1'b1;
            end else begin
                n_valve_on   = 1'b0;
            end
            if (n_valve_on) begin
                n_start_time   = r_now;
                n_start_pulses = r_pulses;
            end
        end

        if (flags[0] && n_valve_on) begin
            n_valve_on = 1'b0;
            n_cause    = CAUSE_STOP_PAD;
        end

        n_drive   = n_valve_on;
        elapsed   = r_now - n_start_time;
        dispensed = r_pulses - n_start_pulses;
        over      = r_cfg.limit_by_time ? (elapsed > {12'd0, n_time_limit})
                                        : (dispensed > {12'd0, n_vol_limit});

        // limits act after the valve was driven this tick
        if (n_valve_on) begin
            if (over) begin
                n_cause = CAUSE_LIMIT;
            end
            if (elapsed > MAX_ON_MS) begin
                n_cause = CAUSE_SAFETY;
            end
            if (over || elapsed > MAX_ON_MS) begin
                n_valve_on = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_on     <= 1'b0;
            r_start_time   <= '0;
            r_start_pulses <= '0;
            r_time_limit   <= '0;
            r_vol_limit    <= '0;
        end else if (advance) begin
            r_valve_on     <= n_valve_on;
            r_start_time   <= n_start_time;
            r_start_pulses <= n_start_pulses;
            r_time_limit   <= n_time_limit;
            r_vol_limit    <= n_vol_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_drive <= n_drive;
            r_out_flags <= flags;
            r_out_cause <= n_cause;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_cause, r_out_flags, r_out_drive};

    `ASSERT_CLK(a_stop_pad_closes, i_clk, i_rst_n, (r_out_valid && r_out_cause == CAUSE_STOP_PAD) |-> !r_out_drive, "stop pad beat shows valve driven")
    `ASSERT_CLK(a_cause_closes, i_clk, i_rst_n, (advance && n_cause != CAUSE_NONE) |=> !r_valve_on, "valve left open after a stop")
    `ASSERT_CLK(a_free_when_empty, i_clk, i_rst_n, !r_out_valid |-> s_axis_tready, "input stalled while result register empty")
    `ASSERT_CLK(a_cause_needs_open, i_clk, i_rst_n, (advance && !r_valve_on && flags[3:1] == '0) |-> (n_cause == CAUSE_NONE), "stop reported with valve closed")

endmodule

`default_nettype wire

// ===== src/tdv_touch_eval.sv =====
// ----------------------------------------------------------------------------
// tdv_touch_eval
// keeps previous pad readings and judges touches every sample period
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tdv_touch_eval (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire tdv_pkg::t_cfg                                 i_cfg,
    input  wire logic                                          i_step,
    input  wire logic [tdv_pkg::NUM_PADS-1:0][tdv_pkg::RD_W-1:0] i_readings,
    output logic      [tdv_pkg::NUM_PADS-1:0]                  o_flags
);
    import tdv_pkg::*;

    logic [NUM_PADS-1:0][RD_W-1:0] r_prev;
    logic [NUM_PADS-1:0][RD_W-1:0] n_prev;
    logic [NUM_PADS-1:0]           r_flags;
    logic [NUM_PADS-1:0]           n_flags;
    logic                          r_primed;
    logic [15:0]                   r_cnt;
    logic [15:0]                   n_cnt;
    logic [NUM_PADS-1:0]           eval_flags;
    logic [15:0]                   period;
    logic [16:0]                   cnt_inc;

    // ratio test as a cross multiply: reading * 2^16 < thr * kept
    always_comb begin
        for (int i = 0; i < NUM_PADS; i++) begin
            eval_flags[i] = (r_prev[i] != '0) &&
                ({i_readings[i], 16'd0} <
                 ({16'd0, i_cfg.thr[i]} * {16'd0, r_prev[i]}));
        end
    end

    assign period  = (i_cfg.period == '0) ? 16'd1 : i_cfg.period;
    assign cnt_inc = {1'b0, r_cnt} + 17'd1;

    always_comb begin
        n_prev  = r_prev;
        n_flags = r_flags;
        n_cnt   = r_cnt;
        if (!r_primed) begin
            n_prev = i_readings;
        end else begin
            if (r_cnt == '0) begin
                n_flags = eval_flags;
                n_prev  = i_readings;
            end
            n_cnt = (cnt_inc >= {1'b0, period}) ? 16'd0 : cnt_inc[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_flags  <= '0;
            r_primed <= 1'b0;
            r_cnt    <= '0;
        end else if (i_step) begin
            r_prev   <= n_prev;
            r_flags  <= n_flags;
            r_primed <= 1'b1;
            r_cnt    <= n_cnt;
        end
    end

    // flags as they stand after this tick
    assign o_flags = n_flags;

    `ASSERT_CLK(a_unprimed_quiet, i_clk, i_rst_n, !r_primed |-> (r_flags == '0 && r_cnt == '0), "touch flags or counter moved before priming")
    `ASSERT_CLK(a_prime_once, i_clk, i_rst_n, (i_step && !r_primed) |=> (r_primed && $stable(r_flags)), "priming tick changed touch flags")
    `ASSERT_CLK(a_hold_between, i_clk, i_rst_n, (i_step && r_primed && r_cnt != '0) |=> $stable(r_flags), "flags changed off an evaluation tick")

endmodule

`default_nettype wire

// ===== sim/touch_dispense_valve_control_tb.sv =====
// ----------------------------------------------------------------------------
// touch_dispense_valve_control_tb
// drives tick beats through the valve controller and checks every result beat
// against a cycle-free behavioral copy of the touch, start, stop and limit
// logic; directed corner cases first, then randomized dispense sessions under
// random source gaps and sink stalls, ending with a full-rate stretch
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_dispense_valve_control_tb;

    import tdv_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    // tick beat layout, lowest bits first: pad0..pad3, pulse_count, now_ms
    typedef struct packed {
        logic [31:0]                   now;
        logic [31:0]                   pulses;
        logic [NUM_PADS-1:0][RD_W-1:0] rd;
    } t_tick;

    // result beat layout, lowest bits first: valve_drive, touched_mask, stop_cause
    typedef struct packed {
        logic       rsv;
        logic [1:0] cause;
        logic [3:0] mask;
        logic       drive;
    } t_result;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_addr    = CFG_THR0;
    logic [59:0]  i_cfg_data    = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;

    touch_dispense_valve_control u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // behavioral copy of the controller
    t_cfg        cfg_m;
    logic [15:0] kept_rd [NUM_PADS];
    logic [3:0]  touch_flags;
    bit          primed;
    logic [15:0] period_cnt;
    bit          valve_open;
    logic [31:0] t_start;
    logic [31:0] p_start;
    logic [19:0] t_limit;
    logic [19:0] v_limit;

    t_result valve_results_due [$];
    int      err_cnt = 0;

    logic [31:0] now_ms    = '0;
    logic [31:0] pulse_cnt = '0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    bit          idle_off = 1'b0;

    task automatic reset_model();
        int i;
        for (i = 0; i < NUM_PADS; i++) begin
            cfg_m.thr[i] = THR_RESET;
            kept_rd[i]   = '0;
        end
        cfg_m.preset_times   = '0;
        cfg_m.preset_volumes = '0;
        cfg_m.limit_by_time  = 1'b1;
        cfg_m.period         = PERIOD_RESET;
        touch_flags = '0;
        primed      = 1'b0;
        period_cnt  = '0;
        valve_open  = 1'b0;
        t_start     = '0;
        p_start     = '0;
        t_limit     = '0;
        v_limit     = '0;
    endtask

    function automatic t_result next_valve_result(input t_tick t);
        t_result     r;
        logic [1:0]  cause;
        logic [3:0]  flags;
        logic [31:0] period;
        logic [31:0] nxt;
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic [31:0] elapsed;
        logic        drive;
        bit          started;
        bit          over;
        int          i;
        cause = CAUSE_NONE;
        if (!primed) begin
            // first tick only loads the kept readings
            for (i = 0; i < NUM_PADS; i++) kept_rd[i] = t.rd[i];
            primed = 1'b1;
        end else begin
            period = (cfg_m.period == 16'd0) ? 32'd1 : {16'd0, cfg_m.period};
            if (period_cnt == 16'd0) begin
                flags = '0;
                for (i = 0; i < NUM_PADS; i++) begin
                    lhs = {t.rd[i], 16'd0};
                    rhs = {16'd0, cfg_m.thr[i]} * {16'd0, kept_rd[i]};
                    if (kept_rd[i] != 16'd0 && lhs < rhs) flags[i] = 1'b1;
                    kept_rd[i] = t.rd[i];
                end
                touch_flags = flags;
            end
            nxt = {16'd0, period_cnt} + 32'd1;
            period_cnt = (nxt >= period) ? 16'd0 : nxt[15:0];
        end

        if (!valve_open) begin
            started = 1'b0;
            for (i = 1; i < NUM_PADS; i++) begin
                if (!started && touch_flags[i]) begin
                    t_limit    = cfg_m.preset_times[PRESET_W*(i-1) +: PRESET_W];
                    v_limit    = cfg_m.preset_volumes[PRESET_W*(i-1) +: PRESET_W];
                    t_start    = t.now;
                    p_start    = t.pulses;
                    valve_open = 1'b1;
                    started    = 1'b1;
                end
            end
        end

        if (touch_flags[0] && valve_open) begin
            valve_open = 1'b0;
            cause      = CAUSE_STOP_PAD;
        end

        // limits close the valve only after it was driven this tick
        drive = valve_open;
        if (valve_open) begin
            elapsed = t.now - t_start;
            if (cfg_m.limit_by_time) over = elapsed > {12'd0, t_limit};
            else                     over = (t.pulses - p_start) > {12'd0, v_limit};
            if (over) begin
                valve_open = 1'b0;
                cause      = CAUSE_LIMIT;
            end
            if (elapsed > MAX_ON_MS) begin
                valve_open = 1'b0;
                cause      = CAUSE_SAFETY;
            end
        end

        r.rsv   = 1'b0;
        r.cause = cause;
        r.mask  = touch_flags;
        r.drive = drive;
        return r;
    endfunction

    task automatic send_tick(input t_tick t);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge i_clk); while (!s_axis_tready);
        valve_results_due.push_back(next_valve_result(t));
    endtask

    task automatic tick_pads(input logic [15:0] p0, input logic [15:0] p1,
                             input logic [15:0] p2, input logic [15:0] p3,
                             input logic [31:0] dt_ms, input logic [31:0] d_pulses);
        t_tick t;
        now_ms    = now_ms + dt_ms;
        pulse_cnt = pulse_cnt + d_pulses;
        t.now     = now_ms;
        t.pulses  = pulse_cnt;
        t.rd[0]   = p0;
        t.rd[1]   = p1;
        t.rd[2]   = p2;
        t.rd[3]   = p3;
        send_tick(t);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (valve_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_config(input t_cfg cfg);
        logic [2:0]  order [8];
        logic [59:0] data;
        int          k;
        order = '{CFG_THR0, CFG_THR1, CFG_THR2, CFG_THR3,
                  CFG_PRESET_TIME, CFG_PRESET_VOL, CFG_LIMIT_TIME, CFG_PERIOD};
        for (k = 0; k < 8; k++) begin
            case (order[k])
                CFG_THR0:        data = {44'd0, cfg.thr[0]};
                CFG_THR1:        data = {44'd0, cfg.thr[1]};
                CFG_THR2:        data = {44'd0, cfg.thr[2]};
                CFG_THR3:        data = {44'd0, cfg.thr[3]};
                CFG_PRESET_TIME: data = cfg.preset_times;
                CFG_PRESET_VOL:  data = cfg.preset_volumes;
                CFG_LIMIT_TIME:  data = {59'd0, cfg.limit_by_time};
                CFG_PERIOD:      data = {44'd0, cfg.period};
                default:         data = '0;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= order[k];
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cfg_m = cfg;
    endtask

    function automatic logic [59:0] rand_presets(input int unsigned span);
        logic [63:0] w;
        logic [59:0] v;
        int          s;
        if ($urandom_range(0, 9) == 0) begin
            w = {$urandom, $urandom};
            v = w[59:0];
        end else begin
            for (s = 0; s < 3; s++) begin
                case ($urandom_range(0, 9))
                    0:       v[PRESET_W*s +: PRESET_W] = 20'hFFFFF;
                    1:       v[PRESET_W*s +: PRESET_W] = 20'd0;
                    default: v[PRESET_W*s +: PRESET_W] = 20'($urandom_range(0, span));
                endcase
            end
        end
        return v;
    endfunction

    // one dispense session: fresh random settings, then ticks from drifting pads
    task automatic run_dispense_phase(input int n_ticks, input bit by_time,
                                      input int unsigned period_lo,
                                      input int unsigned period_hi);
        t_cfg        cfg;
        logic [15:0] base [NUM_PADS];
        logic [15:0] rd [NUM_PADS];
        logic [31:0] dt;
        logic [31:0] dp;
        int          i;
        int          k;
        wait_idle();
        for (i = 0; i < NUM_PADS; i++) begin
            case ($urandom_range(0, 9))
                0:       cfg.thr[i] = 16'd0;
                1:       cfg.thr[i] = 16'hFFFF;
                default: cfg.thr[i] = 16'($urandom_range(45000, 62000));
            endcase
            base[i] = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(8000, 65535));
        end
        cfg.preset_times   = rand_presets(300);
        cfg.preset_volumes = rand_presets(40);
        cfg.limit_by_time  = by_time;
        cfg.period         = 16'($urandom_range(period_lo, period_hi));
        program_config(cfg);
        now_ms    = $urandom;
        pulse_cnt = $urandom;
        if (!idle_off) begin
            src_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 3);
            snk_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 3);
        end
        for (k = 0; k < n_ticks; k++) begin
            if ($urandom_range(0, 24) == 0) begin
                for (i = 0; i < NUM_PADS; i++) rd[i] = 16'($urandom_range(0, 65535));
            end else begin
                for (i = 0; i < NUM_PADS; i++) begin
                    // stop pad touched less often so sessions run for a while
                    if ($urandom_range(0, 99) < ((i == 0) ? 2 : 5))
                        rd[i] = base[i] >> $urandom_range(1, 3);
                    else
                        rd[i] = base[i] - 16'($urandom_range(0, base[i] / 128));
                end
            end
            case ($urandom_range(0, 99))
                0:       dt = $urandom;
                1, 2:    dt = $urandom_range(590000, 1100000);
                default: dt = $urandom_range(0, 25);
            endcase
            dp = ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, 6);
            tick_pads(rd[0], rd[1], rd[2], rd[3], dt, dp);
        end
    endtask

    task automatic test_priming_and_period_change();
        t_cfg cfg;
        tick_pads(16'd0, 16'd0, 16'd0, 16'd0, 32'd10, 32'd1);
        // kept readings are all zero here, so nothing can be touched
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd1);
        // counter not at zero: touch is not seen yet
        tick_pads(16'd40000, 16'd10000, 16'd40000, 16'd40000, 32'd10, 32'd1);
        wait_idle();
        cfg = cfg_m;
        cfg.period = 16'd1;
        program_config(cfg);
        // counter already past the new period, wraps after this tick
        tick_pads(16'd40000, 16'd10000, 16'd40000, 16'd40000, 32'd10, 32'd1);
        tick_pads(16'd40000, 16'd10000, 16'd40000, 16'd40000, 32'd10, 32'd1);
        tick_pads(16'd40000, 16'd10000, 16'd40000, 16'd40000, 32'd10, 32'd1);
    endtask

    task automatic test_threshold_extremes();
        t_cfg cfg;
        wait_idle();
        cfg = cfg_m;
        cfg.thr[0] = 16'd0;
        cfg.thr[1] = 16'hFFFF;
        cfg.thr[2] = 16'hFFFF;
        cfg.thr[3] = 16'd0;
        cfg.period = 16'd0;
        cfg.preset_times = {20'd0, 20'd0, 20'd30};
        program_config(cfg);
        tick_pads(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd10, 32'd0);
        // one count below full scale, just under the largest threshold
        tick_pads(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 32'd10, 32'd0);
        tick_pads(16'd0, 16'd0, 16'd0, 16'd0, 32'd10, 32'd0);
        tick_pads(16'd0, 16'd0, 16'd0, 16'd0, 32'd10, 32'd0);
        tick_pads(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd20, 32'd0);
    endtask

    task automatic test_stop_causes();
        t_cfg cfg;
        wait_idle();
        cfg = cfg_m;
        cfg.thr[0] = THR_RESET;
        cfg.thr[1] = THR_RESET;
        cfg.thr[2] = THR_RESET;
        cfg.thr[3] = THR_RESET;
        cfg.period = 16'd1;
        cfg.limit_by_time  = 1'b1;
        cfg.preset_times   = {20'd0, 20'd50, 20'hFFFFF};
        cfg.preset_volumes = {20'd0, 20'hFFFFF, 20'd5};
        program_config(cfg);
        now_ms = 32'hFFFF_FF00;
        // every pad touched: start on pad 1 and stop pad at once
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd0);
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd0);
        // stop pad while closed
        tick_pads(16'd20000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd0);
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd0);
        tick_pads(16'd40000, 16'd20000, 16'd40000, 16'd40000, 32'd10, 32'd0);
        // preset and safety both exceeded, time wraps
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd1048576, 32'd0);
        tick_pads(16'd40000, 16'd20000, 16'd40000, 16'd40000, 32'd10, 32'd0);
        // safety alone
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd600001, 32'd0);
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd0);
        wait_idle();
        cfg = cfg_m;
        cfg.limit_by_time = 1'b0;
        program_config(cfg);
        pulse_cnt = 32'hFFFF_FFFF;
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd20000, 32'd10, 32'd0);
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd0);
        // pulse count wraps, one past a zero volume limit
        tick_pads(16'd40000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd1);
        tick_pads(16'd40000, 16'd40000, 16'd20000, 16'd40000, 32'd10, 32'd2);
        tick_pads(16'd20000, 16'd40000, 16'd40000, 16'd40000, 32'd10, 32'd2);
    endtask

    task automatic test_random_time_limit();
        repeat (3) run_dispense_phase(200, 1'b1, 0, 2);
    endtask

    task automatic test_random_volume_limit();
        repeat (3) run_dispense_phase(200, 1'b0, 0, 2);
    endtask

    task automatic test_random_periods();
        repeat (2) run_dispense_phase(130, 1'($urandom_range(0, 1)), 3, 8);
        run_dispense_phase(40, 1'b1, 65535, 65535);
    endtask

    task automatic test_full_rate();
        idle_off     = 1'b1;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_dispense_phase(200, 1'($urandom_range(0, 1)), 0, 1);
    endtask

    // sink side stalls in bursts of random length
    int snk_hold = 0;
    always @(posedge i_clk) begin
        if (snk_hold != 0) begin
            snk_hold      <= snk_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
            snk_hold      <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    t_result chk_want;
    t_result chk_got;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            chk_got = m_axis_tdata;
            if (valve_results_due.size() == 0) begin
                $error("result beat %h with nothing expected", m_axis_tdata);
                err_cnt++;
            end else begin
                chk_want = valve_results_due.pop_front();
                if (chk_got.drive !== chk_want.drive) begin
                    $error("valve_drive: expected %0d, got %0d", chk_want.drive, chk_got.drive);
                    err_cnt++;
                end
                if (chk_got.mask !== chk_want.mask) begin
                    $error("touched_mask: expected %0h, got %0h", chk_want.mask, chk_got.mask);
                    err_cnt++;
                end
                if (chk_got.cause !== chk_want.cause) begin
                    $error("stop_cause: expected %0d, got %0d", chk_want.cause, chk_got.cause);
                    err_cnt++;
                end
                if (chk_got.rsv !== chk_want.rsv) begin
                    $error("tdata bit 7: expected %0d, got %0d", chk_want.rsv, chk_got.rsv);
                    err_cnt++;
                end
            end
        end
    end

    // cycles without any beat on any channel
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("touch_dispense_valve_control_tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle_pct = 20;
        snk_idle_pct = 20;
        test_priming_and_period_change();
        test_threshold_extremes();
        test_stop_causes();
        test_random_time_limit();
        test_random_volume_limit();
        test_random_periods();
        test_full_rate();
        wait_idle();
        if (err_cnt == 0) begin
            $display("touch_dispense_valve_control_tb: done, clean");
        end else begin
            $display("touch_dispense_valve_control_tb: done, errors");
        end
        $finish;
    end

endmodule
